/* sv/isa_pkg.sv */
package isa_pkg;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_MOD  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_FDIV = 4'd5;
   localparam logic [3:0] OP_AND  = 4'd6;
   localparam logic [3:0] OP_OR   = 4'd7;
   localparam logic [3:0] OP_XOR  = 4'd8;
   localparam logic [3:0] OP_SHL  = 4'd9;
   localparam logic [3:0] OP_SHR  = 4'd10;
   localparam logic [3:0] OP_NEG  = 4'd11;
   localparam logic [3:0] OP_NOT  = 4'd12;

   localparam int DIV_STAGES = 64;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [63:0] operand_a;
      logic signed [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic        is_div;
      logic        neg_a;
      logic        differ;
      logic        err;
      logic [63:0] b;
      logic [63:0] ub;
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] dq;
   } stage_type;

endpackage

/* sv/isa_div_pipe.sv */
module isa_div_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  isa_pkg::stage_type stage_in,
   output isa_pkg::stage_type stage_out
);
   import isa_pkg::*;

   stage_type st_ff [DIV_STAGES];
   stage_type st_in [DIV_STAGES];

   function automatic stage_type div_step(input stage_type s);
      stage_type   o;
      logic [64:0] t;
      logic [64:0] d;
      logic        ge;
      o = s;
      t = {s.rem, s.dq[63]};
      d = t - {1'b0, s.ub};
      ge = !d[64];
      if (s.is_div) begin
         o.rem = ge ? d[63:0] : t[63:0];
         o.dq  = {s.dq[62:0], ge};
      end
      return o;
   endfunction

   genvar i;
   generate
      for (i = 0; i < DIV_STAGES; i++) begin : g_stage
         if (i == 0) begin : g_first
            assign st_in[i] = div_step(stage_in);
         end else begin : g_next
            assign st_in[i] = div_step(st_ff[i-1]);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               st_ff[i].valid <= 1'b0;
            end else if (advance) begin
               st_ff[i] <= st_in[i];
            end
         end
      end
   endgenerate

   assign stage_out = st_ff[DIV_STAGES-1];

endmodule

/* sv/integer_script_alu.sv */
// Registers from accepted request word to response word, in order:
// input register, decode/multiply, product sum, 64 divide stages, output.
// Throughput: one word per cycle; a stalled response holds the whole pipeline.
// The 64 one-bit restoring divide stages set the depth.
// Reset (synchronous, active high) clears all valid bits; no other state.
module integer_script_alu (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  isa_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output isa_pkg::rsp_type rsp_word
);
   import isa_pkg::*;

   logic      advance;
   logic      in_valid_ff;
   req_type   in_ff;
   stage_type s2_in, s2_ff, s3_in, s3_ff, div_out;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   function automatic logic [63:0] shift_l(input logic [63:0] a, input logic [63:0] n);
      logic [63:0] m;
      m = 64'd0 - n;
      if (n[63]) begin
         return (m >= 64'd64) ? 64'd0 : (a >> m[5:0]);
      end
      return (n >= 64'd64) ? 64'd0 : (a << n[5:0]);
   endfunction

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
         in_ff       <= req_word;
      end
   end

   always_comb begin
      logic [63:0] a, b, p1, p2;
      logic        by_zero;
      a  = in_ff.operand_a;
      b  = in_ff.operand_b;
      p1 = a[31:0] * b[63:32];
      p2 = a[63:32] * b[31:0];
      by_zero = (b == 64'd0);
      s2_in        = '0;
      s2_in.valid  = in_valid_ff;
      s2_in.op     = in_ff.operation;
      s2_in.neg_a  = a[63];
      s2_in.differ = a[63] ^ b[63];
      s2_in.b      = b;
      s2_in.ub     = b[63] ? (64'd0 - b) : b;
      unique case (in_ff.operation)
         OP_ADD: s2_in.res = a + b;
         OP_SUB: s2_in.res = a - b;
         OP_MUL: begin
            s2_in.res = a[31:0] * b[31:0];
            s2_in.rem = {32'd0, p1[31:0]};
            s2_in.dq  = {32'd0, p2[31:0]};
         end
         OP_MOD, OP_DIV, OP_FDIV: begin
            s2_in.err    = by_zero;
            s2_in.is_div = !by_zero;
            s2_in.dq     = a[63] ? (64'd0 - a) : a;
         end
         OP_AND: s2_in.res = a & b;
         OP_OR:  s2_in.res = a | b;
         OP_XOR: s2_in.res = a ^ b;
         OP_SHL: s2_in.res = shift_l(a, b);
         OP_SHR: s2_in.res = shift_l(a, 64'd0 - b);
         OP_NEG: s2_in.res = 64'd0 - a;
         OP_NOT: s2_in.res = ~a;
         default: s2_in.err = 1'b1;
      endcase
   end

   always_comb begin
      logic [31:0] mid_sum;
      s3_in = s2_ff;
      mid_sum = s2_ff.rem[31:0] + s2_ff.dq[31:0];
      if (s2_ff.op == OP_MUL) begin
         s3_in.res = s2_ff.res + {mid_sum, 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   isa_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage_in  (s3_ff),
      .stage_out (div_out)
   );

   always_comb begin
      logic [63:0] q, rm, tq;
      q  = div_out.dq;
      rm = div_out.rem;
      tq = div_out.differ ? (64'd0 - q) : q;
      rsp_in.error  = div_out.err;
      rsp_in.result = div_out.res;
      if (div_out.is_div) begin
         priority if (div_out.op == OP_DIV) begin
            rsp_in.result = tq;
         end else if (div_out.op == OP_FDIV) begin
            rsp_in.result = (rm != 64'd0 && div_out.differ) ? ~q : tq;
         end else if (rm == 64'd0) begin
            rsp_in.result = 64'd0;
         end else if (!div_out.differ) begin
            rsp_in.result = div_out.neg_a ? (64'd0 - rm) : rm;
         end else begin
            rsp_in.result = div_out.neg_a ? (div_out.b - rm) : (div_out.b + rm);
         end
      end else if (div_out.err) begin
         rsp_in.result = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_out.valid;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* sv/isa_checker.sv */
module isa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input isa_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input isa_pkg::rsp_type rsp_word
);
   import isa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.error |-> rsp_word.result == 64'd0)
      else $error("error response with nonzero result");

endmodule

bind integer_script_alu isa_checker u_isa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
